// ----- rtl/ctc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the countdown timer controller: beat structs, state and mode codes,
// register indexes and timing constants. No dependencies.
package ctc_pkg;

    localparam int COUNTER_WIDTH = 32;
    localparam int CMP_W         = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    localparam logic [9:0]  MS_PER_SEC     = 10'd1000;
    localparam logic [7:0]  PHASE_DIV      = 8'd250;   // flash phase; blink uses twice this
    localparam logic [15:0] DEFAULT_START  = 16'd30;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SETTING  = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_PAUSED   = 3'd3,
        ST_ALARMING = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_PRESET   = 3'd1,
        MODE_BUTTON   = 3'd2,
        MODE_LONG     = 3'd3,
        MODE_SLAP     = 3'd4,
        MODE_PROX     = 3'd5,
        MODE_ACTIVATE = 3'd6,
        MODE_START    = 3'd7
    } t_mode;

    localparam logic [2:0] CFG_SETTING_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_DIM_TIMEOUT     = 3'd1;
    localparam logic [2:0] CFG_SLEEP_TIMEOUT   = 3'd2;
    localparam logic [2:0] CFG_AUTO_WAKE       = 3'd3;
    localparam logic [2:0] CFG_ALARM_SILENCE   = 3'd4;
    localparam logic [2:0] CFG_CLOSE_DISTANCE  = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] duration_seconds;
        logic [15:0] distance_mm;
    } t_in;

    typedef struct packed {
        logic [2:0]  timer_state;
        logic [15:0] remaining_seconds;
        logic [15:0] target_seconds;
        logic        display_on;
        logic        display_dimmed;
        logic        alarm_sounding;
        logic        start_beep;
        logic        invert_phase;
        logic        paused_visible;
        logic        clear_display;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_wr;

endpackage

// ----- rtl/ctc_core.sv -----
`timescale 1ns / 1ps
// Timer state, configuration registers and next-state logic for one beat.
// Depends on ctc_pkg.
module ctc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctc_pkg::t_cfg_wr i_cfg,
    input  logic            i_accept,
    input  ctc_pkg::t_in    i_item,
    output ctc_pkg::t_out   o_result
);
    import ctc_pkg::*;

    logic [31:0] r_cfg_set_to, r_cfg_dim_to, r_cfg_sleep_to, r_cfg_silence;
    logic [15:0] r_cfg_wake, r_cfg_close;

    t_state                   r_state, n_state;
    logic [15:0]              r_target, n_target;
    logic [15:0]              r_remain, n_remain;
    logic [15:0]              r_elapsed, n_elapsed;
    logic [9:0]               r_ms, n_ms;
    logic [COUNTER_WIDTH-1:0] r_tis, n_tis;
    logic [COUNTER_WIDTH-1:0] r_tsi, n_tsi;
    logic [7:0]               r_prem, n_prem;
    logic [1:0]               r_pq, n_pq;
    logic                     r_dim, n_dim;
    logic                     r_pow, n_pow;
    logic                     r_buzz, n_buzz;

    logic                     beep, clr, tis_clr;
    logic [COUNTER_WIDTH-1:0] tis_inc, tsi_inc;
    logic [9:0]               ms_inc;
    logic [15:0]              el_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set_to   <= 32'd30000;
            r_cfg_dim_to   <= 32'd30000;
            r_cfg_sleep_to <= 32'd60000;
            r_cfg_wake     <= 16'd10;
            r_cfg_silence  <= 32'd60000;
            r_cfg_close    <= 16'd100;
            r_state        <= ST_IDLE;
            r_target       <= '0;
            r_remain       <= '0;
            r_elapsed      <= '0;
            r_ms           <= '0;
            r_tis          <= '0;
            r_tsi          <= '0;
            r_prem         <= '0;
            r_pq           <= '0;
            r_dim          <= 1'b0;
            r_pow          <= 1'b1;
            r_buzz         <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_SETTING_TIMEOUT: r_cfg_set_to   <= i_cfg.data;
                    CFG_DIM_TIMEOUT:     r_cfg_dim_to   <= i_cfg.data;
                    CFG_SLEEP_TIMEOUT:   r_cfg_sleep_to <= i_cfg.data;
                    CFG_AUTO_WAKE:       r_cfg_wake     <= i_cfg.data[15:0];
                    CFG_ALARM_SILENCE:   r_cfg_silence  <= i_cfg.data;
                    CFG_CLOSE_DISTANCE:  r_cfg_close    <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_state   <= n_state;
                r_target  <= n_target;
                r_remain  <= n_remain;
                r_elapsed <= n_elapsed;
                r_ms      <= n_ms;
                r_tis     <= n_tis;
                r_tsi     <= n_tsi;
                r_prem    <= n_prem;
                r_pq      <= n_pq;
                r_dim     <= n_dim;
                r_pow     <= n_pow;
                r_buzz    <= n_buzz;
            end
        end
    end

    assign tis_inc = (r_tis == CNT_MAX) ? r_tis : r_tis + 1'b1;
    assign tsi_inc = (r_tsi == CNT_MAX) ? r_tsi : r_tsi + 1'b1;
    assign ms_inc  = r_ms + 10'd1;

    always_comb begin
        n_state   = r_state;
        n_target  = r_target;
        n_remain  = r_remain;
        n_elapsed = r_elapsed;
        n_ms      = r_ms;
        n_tis     = r_tis;
        n_tsi     = r_tsi;
        n_prem    = r_prem;
        n_pq      = r_pq;
        n_dim     = r_dim;
        n_pow     = r_pow;
        n_buzz    = r_buzz;
        beep      = 1'b0;
        clr       = 1'b0;
        tis_clr   = 1'b0;
        el_inc    = r_elapsed;

        case (i_item.mode)
            MODE_TICK: begin
                n_tis = tis_inc;
                n_tsi = tsi_inc;
                if (r_tis != CNT_MAX) begin
                    if (r_prem == PHASE_DIV - 8'd1) begin
                        n_prem = '0;
                        n_pq   = r_pq + 2'd1;
                    end else begin
                        n_prem = r_prem + 8'd1;
                    end
                end
                case (r_state)
                    ST_SETTING: begin
                        if (CMP_W'(tis_inc) >= CMP_W'(r_cfg_set_to)) begin
                            n_state = ST_IDLE;
                            tis_clr = 1'b1;
                            clr     = 1'b1;
                            n_pow   = 1'b0;
                        end
                    end
                    ST_RUNNING: begin
                        if (ms_inc >= MS_PER_SEC) begin
                            n_ms = '0;
                            if (r_elapsed != ELAPSED_MAX) begin
                                el_inc = r_elapsed + 16'd1;
                            end
                        end else begin
                            n_ms = ms_inc;
                        end
                        n_elapsed = el_inc;
                        if (el_inc >= r_target) begin
                            n_remain = '0;
                            n_buzz   = 1'b1;
                            n_state  = ST_ALARMING;
                            tis_clr  = 1'b1;
                            n_tsi    = '0;
                            n_dim    = 1'b0;
                            n_pow    = 1'b1;
                        end else begin
                            n_remain = r_target - el_inc;
                            if (n_remain <= r_cfg_wake) begin
                                if (!r_pow || r_dim) begin
                                    n_tsi = '0;
                                    n_dim = 1'b0;
                                    n_pow = 1'b1;
                                end
                            end else if (CMP_W'(tsi_inc) >= CMP_W'(r_cfg_sleep_to)) begin
                                n_pow = 1'b0;
                            end else if (CMP_W'(tsi_inc) >= CMP_W'(r_cfg_dim_to)) begin
                                n_dim = 1'b1;
                            end
                        end
                    end
                    ST_ALARMING: begin
                        if (r_buzz && (CMP_W'(tis_inc) >= CMP_W'(r_cfg_silence))) begin
                            n_buzz = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_PRESET: begin
                if (r_state == ST_SETTING) begin
                    n_tsi    = '0;
                    n_dim    = 1'b0;
                    n_pow    = 1'b1;
                    tis_clr  = 1'b1;
                    n_target = i_item.duration_seconds;
                    n_remain = i_item.duration_seconds;
                end
            end
            MODE_BUTTON: begin
                n_tsi = '0;
                n_dim = 1'b0;
                n_pow = 1'b1;
                case (r_state)
                    ST_SETTING: begin
                        n_remain  = r_target;
                        n_elapsed = '0;
                        n_ms      = '0;
                        beep      = 1'b1;
                        n_state   = ST_RUNNING;
                        tis_clr   = 1'b1;
                    end
                    ST_RUNNING: begin
                        n_state = ST_PAUSED;
                        tis_clr = 1'b1;
                    end
                    ST_PAUSED: begin
                        n_state = ST_RUNNING;
                        tis_clr = 1'b1;
                    end
                    ST_ALARMING: begin
                        n_buzz  = 1'b0;
                        n_state = ST_IDLE;
                        tis_clr = 1'b1;
                        clr     = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_LONG: begin
                if (r_state inside {ST_RUNNING, ST_PAUSED}) begin
                    n_tsi    = '0;
                    n_dim    = 1'b0;
                    n_pow    = 1'b1;
                    n_remain = r_target;
                    n_state  = ST_SETTING;
                    tis_clr  = 1'b1;
                end
            end
            MODE_SLAP: begin
                if (r_state == ST_ALARMING) begin
                    n_buzz  = 1'b0;
                    n_state = ST_IDLE;
                    tis_clr = 1'b1;
                    clr     = 1'b1;
                end else if (r_state == ST_RUNNING) begin
                    n_tsi = '0;
                    n_dim = 1'b0;
                    n_pow = 1'b1;
                end
            end
            MODE_PROX: begin
                if (r_state == ST_RUNNING && i_item.distance_mm < r_cfg_close) begin
                    n_tsi = '0;
                    n_dim = 1'b0;
                    n_pow = 1'b1;
                end
            end
            MODE_ACTIVATE: begin
                n_tsi   = '0;
                n_dim   = 1'b0;
                n_pow   = 1'b1;
                n_buzz  = 1'b0;
                n_state = ST_SETTING;
                tis_clr = 1'b1;
            end
            MODE_START: begin
                n_tsi     = '0;
                n_dim     = 1'b0;
                n_pow     = 1'b1;
                n_target  = (i_item.duration_seconds == 16'd0) ? DEFAULT_START
                                                              : i_item.duration_seconds;
                n_remain  = n_target;
                n_elapsed = '0;
                n_ms      = '0;
                beep      = 1'b1;
                n_state   = ST_RUNNING;
                tis_clr   = 1'b1;
            end
            default: ;
        endcase

        if (tis_clr) begin
            n_tis  = '0;
            n_prem = '0;
            n_pq   = '0;
        end
    end

    always_comb begin
        o_result.timer_state       = n_state;
        o_result.remaining_seconds = n_remain;
        o_result.target_seconds    = n_target;
        o_result.display_on        = n_pow;
        o_result.display_dimmed    = n_dim;
        o_result.alarm_sounding    = n_buzz && (n_state == ST_ALARMING);
        o_result.start_beep        = beep;
        o_result.invert_phase      = (n_state == ST_ALARMING) ? n_pq[0] : 1'b0;
        o_result.paused_visible    = (n_state == ST_PAUSED) ? ~n_pq[1] : 1'b0;
        o_result.clear_display     = clr;
    end

endmodule

// ----- rtl/countdown_timer_controller.sv -----
`timescale 1ns / 1ps
// Top level of the countdown timer controller: input handshake, output register
// with skid stage, configuration port. Depends on ctc_pkg and ctc_core.

// Each accepted beat (a 1 ms tick or an event) updates the timer state in the
// cycle it is taken, and its result beat is registered in the output register
// or the skid stage. One beat is accepted every cycle; the input stalls only
// when both the output register and the skid stage hold results that the
// downstream side has not yet taken. Configuration writes are always ready and
// take effect at the following edge; writes beyond index 5 are ignored.
module countdown_timer_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ctc_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ctc_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import ctc_pkg::*;

    logic    accept;
    logic    out_free;
    t_cfg_wr cfg_wr;
    t_out    result;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_out    r_out;
    t_out    r_skid;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    ctc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_accept (accept),
        .i_item   (i_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a beat while output register is empty");

    a_alarm_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.alarm_sounding) |-> (r_out.timer_state == ST_ALARMING))
        else $error("buzzer reported outside alarming");

    a_beep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.start_beep) |->
            (r_out.timer_state == ST_RUNNING &&
             r_out.remaining_seconds == r_out.target_seconds))
        else $error("start beep without a fresh countdown");

endmodule
